### design/kwcc_pkg.sv
package kwcc_pkg;

  // Default sizes handed to the top level parameters.
  localparam int SAMPLES_DEF   = 1024;
  localparam int EXP_DEPTH_DEF = 1024;
  localparam int MAX_LAGS_DEF  = 31;

  // Operation codes of an input beat.
  localparam logic [1:0] OP_LOAD_ONE = 2'd0;
  localparam logic [1:0] OP_LOAD_TWO = 2'd1;
  localparam logic [1:0] OP_COMPUTE  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  // Register file: index is the word address bit.
  localparam int         CFG_AW        = 3;
  localparam logic       REG_LAG_STEP  = 1'b0;
  localparam logic       REG_LAG_COUNT = 1'b1;
  localparam logic [31:0] LAG_STEP_RST  = 32'h0001_0000;
  localparam logic [4:0]  LAG_COUNT_RST = 5'd4;

  // Saturation bounds of the correlation field.
  localparam logic signed [31:0] CORR_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] CORR_MIN = 32'sh8000_0000;

  // Shared divider: numerator shift register width and step counter width.
  localparam int DIV_SHW = 64;
  localparam int DIV_STW = 7;

  typedef struct packed {
    logic [1:0]         operation;
    logic [47:0]        sample_time;
    logic signed [23:0] sample_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [5:0]  lag_index;
    logic signed [31:0] correlation;
    logic [1:0]         status;
    logic               last_result;
  } out_beat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic base;
    logic sp_start1;
    logic sp_start2;
    logic sp_take1;
    logic sp_take2;
    logic prep;
    logic prep2;
    logic lag;
    logic pair_d;
    logic pair_win;
    logic div_idx;
    logic idx_take;
    logic term;
    logic acc;
    logic next;
    logic fin;
    logic fin_chk;
    logic fin_take;
    logic emit;
  } kwcc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_busy;
    logic base_ok;
    logic skip;
    logic in_win;
    logic last_pair;
    logic wsum_zero;
    logic sat;
    logic last_lag;
  } kwcc_stat_t;

  // Restoring division used only while building the constant table.
  function automatic longint unsigned const_div(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) | ((n >> b) & 64'd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // exp(-f) for f in Q.24, result in Q.30, from a 24 term series.
  function automatic longint unsigned exp_neg_frac(longint unsigned f);
    longint          sum;
    longint unsigned t;
    sum = longint'(64'd1 << 30);
    t   = 64'd1 << 30;
    for (int i = 1; i <= 24; i++) begin
      t = const_div((t * f) >> 24, longint'(i));
      if (i % 2 == 1) begin
        sum = sum - longint'(t);
      end else begin
        sum = sum + longint'(t);
      end
    end
    return longint'(sum);
  endfunction

  // One Gaussian table entry: round(2^15 * exp(-x*x/2)) at the bin center.
  function automatic logic [15:0] gauss_entry(int unsigned e, int unsigned depth);
    longint unsigned e1;
    longint unsigned den;
    longint unsigned o;
    longint unsigned u;
    longint unsigned n;
    longint unsigned v;
    e1  = exp_neg_frac(64'd1 << 24);
    den = 64'd8 * depth * depth;
    o   = 64'd2 * e + 64'd1;
    u   = const_div((64'd25 * o * o) << 24, den);
    n   = u >> 24;
    v   = exp_neg_frac(u & 64'hFF_FFFF);
    for (int x = 0; x < 16; x++) begin
      if (longint'(x) < longint'(n)) begin
        v = (v * e1) >> 30;
      end
    end
    return 16'((v + 64'd16384) >> 15);
  endfunction

endpackage

### design/kwcc_div.sv
module kwcc_div #(
  parameter int DW  = 41,
  parameter int SHW = kwcc_pkg::DIV_SHW,
  parameter int STW = kwcc_pkg::DIV_STW
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [DW-1:0]  rem0,
  input  logic [DW-1:0]  den,
  input  logic [SHW-1:0] sh0,
  input  logic [STW-1:0] steps,
  output logic           busy,
  output logic [SHW-1:0] quo
);

  logic [DW-1:0]  r_r;
  logic [DW-1:0]  den_r;
  logic [SHW-1:0] sh_r;
  logic [SHW-1:0] q_r;
  logic [STW-1:0] cnt_r;
  logic           run_r;
  logic [DW:0]    r2;
  logic           ge;

  // One quotient bit per cycle: shift in the next numerator bit and compare.
  // The divisor is held for the whole run, since the operand select drops it after start.
  assign r2 = {r_r, sh_r[SHW-1]};
  assign ge = r2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= steps;
    end else if (run_r) begin
      cnt_r <= cnt_r - STW'(1);
      if (cnt_r == STW'(1)) begin
        run_r <= 1'b0;
      end
    end
  end

  // Remainder, divisor, numerator and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      r_r   <= rem0;
      den_r <= den;
      sh_r  <= sh0;
      q_r   <= '0;
    end else if (run_r) begin
      r_r  <= ge ? DW'(r2 - {1'b0, den_r}) : DW'(r2);
      sh_r <= {sh_r[SHW-2:0], 1'b0};
      q_r  <= {q_r[SHW-2:0], ge};
    end
  end

  assign busy = run_r;
  assign quo  = q_r;

endmodule

### design/kwcc_dp.sv
module kwcc_dp #(
  parameter int SAMPLES         = kwcc_pkg::SAMPLES_DEF,
  parameter int EXP_TABLE_DEPTH = kwcc_pkg::EXP_DEPTH_DEF,
  parameter int MAX_LAGS        = kwcc_pkg::MAX_LAGS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kwcc_pkg::in_beat_t            in_beat,
  input  kwcc_pkg::kwcc_cmd_t           cmd,
  output kwcc_pkg::kwcc_stat_t          stat,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kwcc_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          out_valid,
  output kwcc_pkg::out_beat_t           out_beat
);

  localparam int IW  = $clog2(SAMPLES);
  localparam int CW  = $clog2(SAMPLES + 1);
  localparam int EAW = $clog2(EXP_TABLE_DEPTH);
  localparam int QW  = EAW + 1;
  localparam int WSW = 16 + 2 * CW;
  localparam int NSW = 48 + 2 * CW;
  localparam int DW  = (WSW > 41) ? WSW : 41;
  localparam int SHW = kwcc_pkg::DIV_SHW;
  localparam int STW = kwcc_pkg::DIV_STW;

  // Configuration and load bookkeeping.
  logic [CW-1:0] cnt1_r, cnt2_r;
  logic          ovf_r;
  logic [31:0]   lag_step_r;
  logic [4:0]    lag_count_r;
  logic [47:0]   first1_r, last1_r, first2_r, last2_r;

  // Sample stores: time in the upper bits, value in the lower.
  logic [71:0]   mem1 [SAMPLES];
  logic [71:0]   mem2 [SAMPLES];
  logic [71:0]   rd1_r, rd2_r;
  logic [IW-1:0] i_r, j_r;

  // Per compute and per lag state.
  logic [4:0]         nl_r;
  logic signed [5:0]  k_r;
  logic [1:0]         base_st_r;
  logic               sp_neg_r;
  logic signed [48:0] m1_r, m2_r;
  logic [50:0]        b_r;
  logic [3:0]         s_r;
  logic [39:0]        bs_r;
  logic signed [38:0] shift_r;

  // Per pair pipeline registers.
  logic signed [52:0]  d4_r;
  logic signed [47:0]  prod_r;
  logic [40+QW-1:0]    numer_r;
  logic [EAW-1:0]      e_r;
  logic [15:0]         rom_r;
  logic signed [48:0]  term_r;
  logic [WSW-1:0]      wsum_r;
  logic signed [NSW-1:0] nsum_r;
  logic [NSW-1:0]      mag_r;
  logic                neg_r;
  logic [1:0]          res_st_r;
  logic signed [31:0]  res_corr_r;
  logic                out_valid_r;
  kwcc_pkg::out_beat_t out_beat_r;

  // Divider hookup.
  logic           div_start;
  logic [DW-1:0]  div_rem0, div_den;
  logic [SHW-1:0] div_sh0;
  logic [STW-1:0] div_steps;
  logic           div_busy;
  logic [SHW-1:0] div_quo;

  // Combinational helpers.
  logic               wr1, wr2, full1, full2, few, cfg_wr;
  logic signed [48:0] span1, span2, sp_span;
  logic [47:0]        sp_mag;
  logic [CW-1:0]      sp_den;
  logic signed [48:0] sp_val, mmin;
  logic [50:0]        mu;
  logic [3:0]         s_nxt;
  logic [4:0]         nl_nxt;
  logic [47:0]        t1, t2;
  logic signed [23:0] v1, v2;
  logic signed [50:0] diff;
  logic signed [52:0] bsg;
  logic [52:0]        a_abs;
  logic [39:0]        a_sh;
  logic [QW-1:0]      qi;
  logic signed [31:0] pw;
  logic [WSW-1:0]     mag_hi;
  logic [31:0]        q32;
  logic               last_i, last_j, fin_start;

  // Constant Gaussian table, read through a registered port.
  logic [15:0] tab_w [EXP_TABLE_DEPTH];
  for (genvar g = 0; g < EXP_TABLE_DEPTH; g++) begin : g_tab
    localparam logic [15:0] GV = kwcc_pkg::gauss_entry(g, EXP_TABLE_DEPTH);
    assign tab_w[g] = GV;
  end

  assign wr1    = cmd.load && (in_beat.operation == kwcc_pkg::OP_LOAD_ONE);
  assign wr2    = cmd.load && (in_beat.operation == kwcc_pkg::OP_LOAD_TWO);
  assign full1  = cnt1_r == CW'(SAMPLES);
  assign full2  = cnt2_r == CW'(SAMPLES);
  assign few    = (cnt1_r < CW'(2)) || (cnt2_r < CW'(2));
  assign cfg_wr = psel && penable && pwrite;

  // Spacing numerator and denominator for the series being divided.
  assign span1   = $signed({1'b0, last1_r}) - $signed({1'b0, first1_r});
  assign span2   = $signed({1'b0, last2_r}) - $signed({1'b0, first2_r});
  assign sp_span = cmd.sp_start2 ? span2 : span1;
  assign sp_mag  = sp_span[48] ? 48'(-sp_span) : sp_span[47:0];
  assign sp_den  = cmd.sp_start2 ? (cnt2_r - CW'(1)) : (cnt1_r - CW'(1));
  assign sp_val  = sp_neg_r ? -$signed({1'b0, div_quo[47:0]}) : $signed({1'b0, div_quo[47:0]});

  assign mmin   = (m1_r < m2_r) ? m1_r : m2_r;
  assign mu     = {3'b000, mmin[47:0]};
  assign nl_nxt = (lag_count_r > 5'(MAX_LAGS)) ? 5'(MAX_LAGS) : lag_count_r;

  // Least shift that brings the window bound under 2^40.
  always_comb begin
    s_nxt = 4'd11;
    for (int x = 11; x >= 0; x--) begin
      if ((b_r >> x) < 51'(64'd1 << 40)) begin
        s_nxt = 4'(x);
      end
    end
  end

  assign t1   = rd1_r[71:24];
  assign v1   = $signed(rd1_r[23:0]);
  assign t2   = rd2_r[71:24];
  assign v2   = $signed(rd2_r[23:0]);
  assign diff = $signed({3'b000, t2}) - $signed({3'b000, t1}) - 51'(shift_r);

  assign bsg    = $signed({2'b00, b_r});
  assign a_abs  = d4_r[52] ? 53'(-d4_r) : 53'(d4_r);
  assign a_sh   = 40'(a_abs >> s_r);
  assign qi     = div_quo[QW-1:0];
  assign pw     = 32'(prod_r >>> 16);
  assign mag_hi = mag_r[NSW-1:32];
  assign q32    = div_quo[31:0];

  assign last_i    = i_r == IW'(cnt1_r - CW'(1));
  assign last_j    = j_r == IW'(cnt2_r - CW'(1));
  assign fin_start = cmd.fin_chk && (wsum_r != '0) && (mag_hi < wsum_r);

  // Divider operand selection for spacing, table index and final ratio.
  always_comb begin
    div_start = 1'b0;
    div_rem0  = '0;
    div_den   = '0;
    div_sh0   = '0;
    div_steps = '0;
    if (cmd.sp_start1 || cmd.sp_start2) begin
      div_start = 1'b1;
      div_den   = DW'(sp_den);
      div_sh0   = {sp_mag, {(SHW-48){1'b0}}};
      div_steps = STW'(48);
    end else if (cmd.div_idx) begin
      div_start = 1'b1;
      div_rem0  = DW'(numer_r >> QW);
      div_den   = DW'(bs_r);
      div_sh0   = {numer_r[QW-1:0], {(SHW-QW){1'b0}}};
      div_steps = STW'(QW);
    end else if (fin_start) begin
      div_start = 1'b1;
      div_rem0  = DW'(mag_hi);
      div_den   = DW'(wsum_r);
      div_sh0   = {mag_r[31:0], {(SHW-32){1'b0}}};
      div_steps = STW'(32);
    end
  end

  kwcc_div #(
    .DW  (DW),
    .SHW (SHW),
    .STW (STW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .rem0  (div_rem0),
    .den   (div_den),
    .sh0   (div_sh0),
    .steps (div_steps),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  // Control state: counts, overflow flag, registers and the result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt1_r      <= '0;
      cnt2_r      <= '0;
      ovf_r       <= 1'b0;
      lag_step_r  <= kwcc_pkg::LAG_STEP_RST;
      lag_count_r <= kwcc_pkg::LAG_COUNT_RST;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cfg_wr) begin
        if (paddr[2] == kwcc_pkg::REG_LAG_COUNT) begin
          lag_count_r <= pwdata[4:0];
        end else begin
          lag_step_r <= pwdata;
        end
      end
      if (wr1) begin
        if (full1) begin
          ovf_r <= 1'b1;
        end else begin
          cnt1_r <= cnt1_r + CW'(1);
        end
      end
      if (wr2) begin
        if (full2) begin
          ovf_r <= 1'b1;
        end else begin
          cnt2_r <= cnt2_r + CW'(1);
        end
      end
      if (cmd.emit && stat.last_lag) begin
        cnt1_r <= '0;
        cnt2_r <= '0;
        ovf_r  <= 1'b0;
      end
    end
  end

  // Sample stores and their registered read ports.
  always_ff @(posedge clk) begin
    if (wr1 && !full1) begin
      mem1[cnt1_r[IW-1:0]] <= {in_beat.sample_time, in_beat.sample_value};
    end
    if (wr2 && !full2) begin
      mem2[cnt2_r[IW-1:0]] <= {in_beat.sample_time, in_beat.sample_value};
    end
    rd1_r <= mem1[i_r];
    rd2_r <= mem2[j_r];
    rom_r <= tab_w[e_r];
  end

  // First and last time of each series give the mean spacing.
  always_ff @(posedge clk) begin
    if (wr1 && !full1) begin
      last1_r <= in_beat.sample_time;
      if (cnt1_r == '0) begin
        first1_r <= in_beat.sample_time;
      end
    end
    if (wr2 && !full2) begin
      last2_r <= in_beat.sample_time;
      if (cnt2_r == '0) begin
        first2_r <= in_beat.sample_time;
      end
    end
  end

  // Compute setup: lag range, base status, spacing and window bound.
  always_ff @(posedge clk) begin
    if (cmd.base) begin
      nl_r <= nl_nxt;
      k_r  <= -$signed({1'b0, nl_nxt});
      if (few) begin
        base_st_r <= kwcc_pkg::ST_FEW;
      end else if (ovf_r) begin
        base_st_r <= kwcc_pkg::ST_OVF;
      end else begin
        base_st_r <= kwcc_pkg::ST_OK;
      end
    end
    if (cmd.sp_start1 || cmd.sp_start2) begin
      sp_neg_r <= sp_span[48];
    end
    if (cmd.sp_take1) begin
      m1_r <= sp_val;
    end
    if (cmd.sp_take2) begin
      m2_r <= sp_val;
    end
    if (cmd.prep) begin
      if (mmin <= 49'sd0) begin
        base_st_r <= kwcc_pkg::ST_ZERO;
      end
      b_r <= (mu << 2) + mu;
    end
    if (cmd.prep2) begin
      s_r  <= s_nxt;
      bs_r <= 40'(b_r >> s_nxt);
    end
    if (cmd.emit && !stat.last_lag) begin
      k_r <= k_r + 6'sd1;
    end
  end

  // Pair walk: window test, table index, weight and weighted product sums, then the final ratio and the result beat.
  always_ff @(posedge clk) begin
    if (cmd.lag) begin
      shift_r    <= k_r * $signed({1'b0, lag_step_r});
      wsum_r     <= '0;
      nsum_r     <= '0;
      i_r        <= '0;
      j_r        <= '0;
      res_st_r   <= base_st_r;
      res_corr_r <= '0;
    end
    if (cmd.pair_d) begin
      d4_r   <= $signed({diff, 2'b00});
      prod_r <= v1 * v2;
    end
    if (cmd.pair_win) begin
      numer_r <= (40+QW)'(a_sh) * (40+QW)'(EXP_TABLE_DEPTH);
    end
    if (cmd.idx_take) begin
      e_r <= (qi > QW'(EXP_TABLE_DEPTH - 1)) ? EAW'(EXP_TABLE_DEPTH - 1) : qi[EAW-1:0];
    end
    if (cmd.term) begin
      term_r <= pw * $signed({1'b0, rom_r});
      wsum_r <= wsum_r + WSW'(rom_r);
    end
    if (cmd.acc) begin
      nsum_r <= nsum_r + NSW'(term_r);
    end
    if (cmd.next) begin
      if (last_j) begin
        j_r <= '0;
        i_r <= i_r + IW'(1);
      end else begin
        j_r <= j_r + IW'(1);
      end
    end
    if (cmd.fin) begin
      neg_r <= nsum_r[NSW-1];
      mag_r <= nsum_r[NSW-1] ? NSW'(-nsum_r) : NSW'(nsum_r);
    end
    if (cmd.fin_chk) begin
      if (wsum_r == '0) begin
        res_st_r   <= kwcc_pkg::ST_ZERO;
        res_corr_r <= '0;
      end else if (mag_hi >= wsum_r) begin
        res_corr_r <= neg_r ? kwcc_pkg::CORR_MIN : kwcc_pkg::CORR_MAX;
      end
    end
    if (cmd.fin_take) begin
      if (!neg_r) begin
        res_corr_r <= (q32 > 32'h7FFF_FFFF) ? kwcc_pkg::CORR_MAX : $signed(q32);
      end else begin
        res_corr_r <= (q32 > 32'h8000_0000) ? kwcc_pkg::CORR_MIN : -$signed(q32);
      end
    end
    if (cmd.emit) begin
      out_beat_r.lag_index   <= k_r;
      out_beat_r.correlation <= res_corr_r;
      out_beat_r.status      <= res_st_r;
      out_beat_r.last_result <= stat.last_lag;
    end
  end

  // Status back to the controller.
  assign stat.div_busy  = div_busy;
  assign stat.base_ok   = !few && !ovf_r;
  assign stat.skip      = base_st_r != kwcc_pkg::ST_OK;
  assign stat.in_win    = (d4_r >= -bsg) && (d4_r < bsg);
  assign stat.last_pair = last_i && last_j;
  assign stat.wsum_zero = wsum_r == '0;
  assign stat.sat       = mag_hi >= wsum_r;
  assign stat.last_lag  = k_r == $signed({1'b0, nl_r});

  assign prdata    = (paddr[2] == kwcc_pkg::REG_LAG_COUNT) ? {27'b0, lag_count_r} : lag_step_r;
  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  // Sample counts never pass the store depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt1_r <= CW'(SAMPLES) && cnt2_r <= CW'(SAMPLES))
    else $error("sample count beyond store depth");

  // The final result of a compute empties both series.
  a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit && stat.last_lag |=> cnt1_r == '0 && cnt2_r == '0 && !ovf_r)
    else $error("series not cleared after compute");

  // The shared divider is never restarted while it runs.
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // A pair inside five widths yields a table index of at most the depth.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.idx_take |-> qi <= QW'(EXP_TABLE_DEPTH))
    else $error("table index quotient out of range");

  // A result strobe comes in the cycle after an emit command.
  a_emit_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(cmd.emit))
    else $error("result strobe without emit");

endmodule

### design/kwcc_ctrl.sv
module kwcc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [1:0]           op,
  input  kwcc_pkg::kwcc_stat_t stat,
  output kwcc_pkg::kwcc_cmd_t  cmd,
  output logic                 busy
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_BASE  = 5'd1;
  localparam logic [4:0] S_SPD1  = 5'd2;
  localparam logic [4:0] S_SPW1  = 5'd3;
  localparam logic [4:0] S_SPD2  = 5'd4;
  localparam logic [4:0] S_SPW2  = 5'd5;
  localparam logic [4:0] S_PREP  = 5'd6;
  localparam logic [4:0] S_PREP2 = 5'd7;
  localparam logic [4:0] S_LAG   = 5'd8;
  localparam logic [4:0] S_PA    = 5'd9;
  localparam logic [4:0] S_PB    = 5'd10;
  localparam logic [4:0] S_PC    = 5'd11;
  localparam logic [4:0] S_PD    = 5'd12;
  localparam logic [4:0] S_PW    = 5'd13;
  localparam logic [4:0] S_PR    = 5'd14;
  localparam logic [4:0] S_PT    = 5'd15;
  localparam logic [4:0] S_PACC  = 5'd16;
  localparam logic [4:0] S_NEXT  = 5'd17;
  localparam logic [4:0] S_FIN   = 5'd18;
  localparam logic [4:0] S_FIN2  = 5'd19;
  localparam logic [4:0] S_FW    = 5'd20;
  localparam logic [4:0] S_EMIT  = 5'd21;

  logic [4:0] state_r, state_nxt;

  // Sequencing of loads, setup, the pair walk per lag and the results.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = (op == kwcc_pkg::OP_LOAD_ONE) || (op == kwcc_pkg::OP_LOAD_TWO);
          if (op == kwcc_pkg::OP_COMPUTE) begin
            state_nxt = S_BASE;
          end
        end
      end
      S_BASE: begin
        cmd.base  = 1'b1;
        state_nxt = stat.base_ok ? S_SPD1 : S_LAG;
      end
      S_SPD1: begin
        cmd.sp_start1 = 1'b1;
        state_nxt     = S_SPW1;
      end
      S_SPW1: begin
        if (!stat.div_busy) begin
          cmd.sp_take1 = 1'b1;
          state_nxt    = S_SPD2;
        end
      end
      S_SPD2: begin
        cmd.sp_start2 = 1'b1;
        state_nxt     = S_SPW2;
      end
      S_SPW2: begin
        if (!stat.div_busy) begin
          cmd.sp_take2 = 1'b1;
          state_nxt    = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_PREP2;
      end
      S_PREP2: begin
        cmd.prep2 = 1'b1;
        state_nxt = S_LAG;
      end
      S_LAG: begin
        cmd.lag   = 1'b1;
        state_nxt = stat.skip ? S_EMIT : S_PA;
      end
      S_PA: begin
        state_nxt = S_PB;
      end
      S_PB: begin
        cmd.pair_d = 1'b1;
        state_nxt  = S_PC;
      end
      S_PC: begin
        cmd.pair_win = 1'b1;
        state_nxt    = stat.in_win ? S_PD : S_NEXT;
      end
      S_PD: begin
        cmd.div_idx = 1'b1;
        state_nxt   = S_PW;
      end
      S_PW: begin
        if (!stat.div_busy) begin
          cmd.idx_take = 1'b1;
          state_nxt    = S_PR;
        end
      end
      S_PR: begin
        state_nxt = S_PT;
      end
      S_PT: begin
        cmd.term  = 1'b1;
        state_nxt = S_PACC;
      end
      S_PACC: begin
        cmd.acc   = 1'b1;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        cmd.next  = 1'b1;
        state_nxt = stat.last_pair ? S_FIN : S_PA;
      end
      S_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        cmd.fin_chk = 1'b1;
        state_nxt   = (stat.wsum_zero || stat.sat) ? S_EMIT : S_FW;
      end
      S_FW: begin
        if (!stat.div_busy) begin
          cmd.fin_take = 1'b1;
          state_nxt    = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = stat.last_lag ? S_IDLE : S_LAG;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

endmodule

### design/kernel_weighted_cross_correlation_unit.sv
// Load beats leave busy low; a new beat is accepted in every cycle while busy is low.
// A compute beat raises busy for setup, two 48-step spacing divides on the shared bit-serial
// divider, skipped when a series is short or overflowed. Each lag then walks every pair; a pair
// inside the window also runs a table index divide, and the final ratio divide is skipped when the
// weight sum is zero or saturates. A skipped lag goes straight to its result.
// One result per lag leaves in the cycle after its emit on a one-cycle strobe; the receiver cannot
// stall. Reset clears counts, overflow flag, registers and control, not the stores.
module kernel_weighted_cross_correlation_unit #(
  parameter int SAMPLES         = kwcc_pkg::SAMPLES_DEF,
  parameter int EXP_TABLE_DEPTH = kwcc_pkg::EXP_DEPTH_DEF,
  parameter int MAX_LAGS        = kwcc_pkg::MAX_LAGS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  kwcc_pkg::in_beat_t          in_beat,
  output logic                        out_valid,
  output kwcc_pkg::out_beat_t         out_beat,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [kwcc_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  kwcc_pkg::kwcc_cmd_t  cmd;
  kwcc_pkg::kwcc_stat_t stat;

  // Sequencer.
  kwcc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_beat.operation),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Stores, arithmetic and register file.
  kwcc_dp #(
    .SAMPLES         (SAMPLES),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
    .MAX_LAGS        (MAX_LAGS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_beat   (in_beat),
    .cmd       (cmd),
    .stat      (stat),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .out_valid (out_valid),
    .out_beat  (out_beat)
  );

  assign pready = 1'b1;

endmodule

### bench/kernel_weighted_cross_correlation_unit_test.sv
module kernel_weighted_cross_correlation_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  DEPTH      = kwcc_pkg::EXP_DEPTH_DEF;
  localparam int  STORE_SIZE = kwcc_pkg::SAMPLES_DEF;
  localparam int  CAP_LAGS   = kwcc_pkg::MAX_LAGS_DEF;
  localparam longint CYCLE_LIMIT = 8000000;
  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam logic [kwcc_pkg::CFG_AW-1:0] ADDR_LAG_STEP  = {kwcc_pkg::REG_LAG_STEP, 2'b00};
  localparam logic [kwcc_pkg::CFG_AW-1:0] ADDR_LAG_COUNT = {kwcc_pkg::REG_LAG_COUNT, 2'b00};

  // Scoreboard: mirrors the sample stores and predicts one beat per lag on compute.
  class corr_scoreboard;
    logic [15:0]         gauss_lut[DEPTH];
    longint unsigned     times_a[$];
    longint unsigned     times_b[$];
    longint              vals_a[$];
    longint              vals_b[$];
    bit                  store_full_hit;
    logic [31:0]         step_q16;
    logic [4:0]          lags_each_side;
    kwcc_pkg::out_beat_t lag_results[$];
    int                  failures;
    int                  beats_checked;
    int                  computes_seen;

    function new();
      longint unsigned e1, den, o, u, n, v;
      e1  = exp_frac(64'd1 << 24);
      den = 64'd8 * DEPTH * DEPTH;
      for (int e = 0; e < DEPTH; e++) begin
        o = 64'd2 * e + 64'd1;
        u = ((64'd25 * o * o) << 24) / den;
        n = u >> 24;
        v = exp_frac(u & 64'hFF_FFFF);
        while (n > 0) begin
          v = (v * e1) >> 30;
          n--;
        end
        gauss_lut[e] = 16'((v + 64'd16384) >> 15);
      end
      step_q16       = kwcc_pkg::LAG_STEP_RST;
      lags_each_side = kwcc_pkg::LAG_COUNT_RST;
    endfunction

    // Series expansion of exp(-f), f in Q.24, result in Q.30.
    function longint unsigned exp_frac(longint unsigned f);
      longint          sum;
      longint unsigned t;
      sum = longint'(64'd1 << 30);
      t   = 64'd1 << 30;
      for (int i = 1; i <= 24; i++) begin
        t = ((t * f) >> 24) / longint'(i);
        if (i % 2 == 1) begin
          sum = sum - longint'(t);
        end else begin
          sum = sum + longint'(t);
        end
      end
      return longint'(sum);
    endfunction

    function void set_reg(logic [kwcc_pkg::CFG_AW-1:0] addr, logic [31:0] data);
      if (addr == ADDR_LAG_STEP) begin
        step_q16 = data;
      end else if (addr == ADDR_LAG_COUNT) begin
        lags_each_side = data[4:0];
      end
    endfunction

    // Kernel-weighted mean of y1*y2 for lag k, with m the smaller spacing.
    function void weigh_lag(int k, longint m, output logic [1:0] st, output logic [31:0] corr);
      longint            shift, d4, p, term;
      longint unsigned   b, bs, a, e, wsum;
      int                s;
      logic signed [127:0] num, den, q;
      shift = longint'(k) * longint'({32'd0, step_q16});
      b     = 64'd5 * longint'(m);
      s     = 0;
      while ((b >> s) >= (64'd1 << 40)) s++;
      bs   = b >> s;
      num  = 0;
      wsum = 0;
      for (int i = 0; i < times_a.size(); i++) begin
        for (int j = 0; j < times_b.size(); j++) begin
          d4 = 4 * (longint'(times_b[j]) - longint'(times_a[i]) - shift);
          if (d4 < -longint'(b) || d4 >= longint'(b)) continue;
          a = d4 < 0 ? longint'(-d4) : longint'(d4);
          e = ((a >> s) * DEPTH) / bs;
          if (e > DEPTH - 1) e = DEPTH - 1;
          wsum = wsum + gauss_lut[e];
          p    = (vals_a[i] * vals_b[j]) >>> 16;
          term = p * longint'({48'd0, gauss_lut[e]});
          num  = num + term;
        end
      end
      if (wsum == 0) begin
        st   = kwcc_pkg::ST_ZERO;
        corr = '0;
        return;
      end
      den = {64'd0, wsum};
      q   = num / den;
      st  = kwcc_pkg::ST_OK;
      if (q > 128'sh7FFF_FFFF) corr = kwcc_pkg::CORR_MAX;
      else if (q < -128'sh8000_0000) corr = kwcc_pkg::CORR_MIN;
      else corr = q[31:0];
    endfunction

    function void note_input(kwcc_pkg::in_beat_t b);
      int                  nl;
      longint              m, ma, mb;
      logic [1:0]          base_st;
      kwcc_pkg::out_beat_t r;
      case (b.operation)
        kwcc_pkg::OP_LOAD_ONE: begin
          if (times_a.size() < STORE_SIZE) begin
            times_a.push_back(b.sample_time);
            vals_a.push_back(longint'(b.sample_value));
          end else begin
            store_full_hit = 1;
          end
        end
        kwcc_pkg::OP_LOAD_TWO: begin
          if (times_b.size() < STORE_SIZE) begin
            times_b.push_back(b.sample_time);
            vals_b.push_back(longint'(b.sample_value));
          end else begin
            store_full_hit = 1;
          end
        end
        kwcc_pkg::OP_COMPUTE: begin
          computes_seen++;
          nl = lags_each_side > CAP_LAGS ? CAP_LAGS : lags_each_side;
          m  = 0;
          if (times_a.size() < 2 || times_b.size() < 2) begin
            base_st = kwcc_pkg::ST_FEW;
          end else if (store_full_hit) begin
            base_st = kwcc_pkg::ST_OVF;
          end else begin
            base_st = kwcc_pkg::ST_OK;
            ma = (longint'(times_a[$]) - longint'(times_a[0])) / longint'(times_a.size() - 1);
            mb = (longint'(times_b[$]) - longint'(times_b[0])) / longint'(times_b.size() - 1);
            m  = ma < mb ? ma : mb;
          end
          for (int k = -nl; k <= nl; k++) begin
            r.lag_index   = 6'(k);
            r.correlation = '0;
            r.status      = base_st;
            r.last_result = (k == nl);
            if (base_st == kwcc_pkg::ST_OK) begin
              if (m <= 0) r.status = kwcc_pkg::ST_ZERO;
              else weigh_lag(k, m, r.status, r.correlation);
            end
            lag_results.push_back(r);
          end
          times_a.delete();
          times_b.delete();
          vals_a.delete();
          vals_b.delete();
          store_full_hit = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(kwcc_pkg::out_beat_t got);
      kwcc_pkg::out_beat_t want;
      if (lag_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $realtime, got);
        failures++;
        return;
      end
      want = lag_results.pop_front();
      beats_checked++;
      if (got.lag_index !== want.lag_index) begin
        $display("%0t: lag_index expected %0d got %0d", $realtime, want.lag_index, got.lag_index);
        failures++;
      end
      if (got.correlation !== want.correlation) begin
        $display("%0t: correlation (lag %0d) expected %0d got %0d", $realtime,
                 want.lag_index, want.correlation, got.correlation);
        failures++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status (lag %0d) expected %0d got %0d", $realtime,
                 want.lag_index, want.status, got.status);
        failures++;
      end
      if (got.last_result !== want.last_result) begin
        $display("%0t: last_result (lag %0d) expected %0d got %0d", $realtime,
                 want.lag_index, want.last_result, got.last_result);
        failures++;
      end
    endfunction
  endclass

  logic                          clk = 0;
  logic                          rst_n = 0;
  logic                          start = 0;
  logic                          busy;
  kwcc_pkg::in_beat_t            in_beat = '0;
  logic                          out_valid;
  kwcc_pkg::out_beat_t           out_beat;
  logic                          psel = 0;
  logic                          penable = 0;
  logic                          pwrite = 0;
  logic [kwcc_pkg::CFG_AW-1:0]   paddr = '0;
  logic [31:0]                   pwdata = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  corr_scoreboard sb = new();
  longint cycles = 0;
  bit     quiet_phase;

  kernel_weighted_cross_correlation_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_beat(in_beat),
    .out_valid(out_valid), .out_beat(out_beat), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Accepted beats on both channels go to the scoreboard at the same edge as the block.
  always @(posedge clk) begin
    if (rst_n && start && !busy) sb.note_input(in_beat);
    if (rst_n && out_valid) sb.check_result(out_beat);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Send one beat after an optional idle gap; start stays high afterwards.
  task automatic send(logic [1:0] op, logic [47:0] t, logic [23:0] v);
    int gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 17);
    if ($urandom_range(0, 2) == 0) gap = 0;
    repeat (gap) begin
      start <= 0;
      @(posedge clk);
    end
    start   <= 1;
    in_beat <= '{operation: op, sample_time: t, sample_value: v};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Let every lag beat arrive, then give the block time to settle before a write.
  task automatic wait_idle();
    start <= 0;
    @(posedge clk);
    while (sb.lag_results.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic cfg_write(logic [kwcc_pkg::CFG_AW-1:0] addr, logic [31:0] data);
    psel    <= 1;
    penable <= 0;
    pwrite  <= 1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(addr, data);
    psel    <= 0;
    penable <= 0;
    pwrite  <= 0;
    @(posedge clk);
  endtask

  task automatic set_lags(logic [31:0] step, logic [4:0] count);
    wait_idle();
    cfg_write(ADDR_LAG_STEP, step);
    cfg_write(ADDR_LAG_COUNT, {27'd0, count});
  endtask

  // One set: two series, ascending and near each other unless scrambled, then a compute.
  task automatic run_set(int n_one, int n_two, bit scramble);
    logic [47:0] base, t_one, t_two;
    int          left_one, left_two;
    base     = 48'({$urandom(), $urandom()});
    base     = base > 48'hFFFF_F000_0000 ? base - 48'h0000_1000_0000 : base;
    t_one    = base;
    t_two    = base + 48'($urandom_range(0, 1 << 18));
    left_one = n_one;
    left_two = n_two;
    while (left_one + left_two > 0) begin
      if (left_two == 0 || (left_one > 0 && $urandom_range(0, 1))) begin
        send(kwcc_pkg::OP_LOAD_ONE, scramble ? 48'({$urandom(), $urandom()}) : t_one,
             24'($urandom()));
        t_one = t_one + 48'($urandom_range(0, 1 << 19));
        left_one--;
      end else begin
        send(kwcc_pkg::OP_LOAD_TWO, scramble ? 48'({$urandom(), $urandom()}) : t_two,
             24'($urandom()));
        t_two = t_two + 48'($urandom_range(0, 1 << 19));
        left_two--;
      end
      if ($urandom_range(0, 15) == 0) begin
        send(OP_IGNORED, 48'({$urandom(), $urandom()}), 24'($urandom()));
      end
    end
    send(kwcc_pkg::OP_COMPUTE, 48'({$urandom(), $urandom()}), 24'($urandom()));
  endtask

  initial begin
    logic [31:0] step;
    logic [4:0]  count;
    int          noise;
    quiet_phase = 1;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty compute, ignored op, extremes of time and value at reset settings.
    send(kwcc_pkg::OP_COMPUTE, '0, '0);
    send(OP_IGNORED, 48'hFFFF_FFFF_FFFF, 24'h7F_FFFF);
    send(kwcc_pkg::OP_LOAD_ONE, 48'h0, 24'h80_0000);
    send(kwcc_pkg::OP_LOAD_ONE, 48'h0001_0000, 24'h7F_FFFF);
    send(kwcc_pkg::OP_LOAD_TWO, 48'h0, 24'h80_0000);
    send(kwcc_pkg::OP_LOAD_TWO, 48'h0001_0000, 24'h80_0000);
    send(kwcc_pkg::OP_COMPUTE, '0, '0);
    // Top of the time range and full-scale values.
    send(kwcc_pkg::OP_LOAD_ONE, 48'hFFFF_FFFE_0000, 24'h7F_FFFF);
    send(kwcc_pkg::OP_LOAD_ONE, 48'hFFFF_FFFF_FFFF, 24'h7F_FFFF);
    send(kwcc_pkg::OP_LOAD_TWO, 48'hFFFF_FFFE_8000, 24'h7F_FFFF);
    send(kwcc_pkg::OP_LOAD_TWO, 48'hFFFF_FFFF_8000, 24'h80_0000);
    send(kwcc_pkg::OP_COMPUTE, '0, '0);
    // Descending times give a negative width; equal times give zero width.
    send(kwcc_pkg::OP_LOAD_ONE, 48'h0005_0000, 24'h10_0000);
    send(kwcc_pkg::OP_LOAD_ONE, 48'h0001_0000, 24'h10_0000);
    send(kwcc_pkg::OP_LOAD_TWO, 48'h0001_0000, 24'h10_0000);
    send(kwcc_pkg::OP_LOAD_TWO, 48'h0003_0000, 24'h10_0000);
    send(kwcc_pkg::OP_COMPUTE, '0, '0);
    send(kwcc_pkg::OP_LOAD_ONE, 48'h0002_0000, 24'h01_0000);
    send(kwcc_pkg::OP_LOAD_ONE, 48'h0002_0000, 24'h01_0000);
    send(kwcc_pkg::OP_LOAD_TWO, 48'h0002_0000, 24'h01_0000);
    send(kwcc_pkg::OP_LOAD_TWO, 48'h0002_0000, 24'h01_0000);
    send(kwcc_pkg::OP_COMPUTE, '0, '0);
    // Only one series with enough samples.
    send(kwcc_pkg::OP_LOAD_ONE, 48'h1, 24'h1);
    send(kwcc_pkg::OP_LOAD_TWO, 48'h2, 24'h2);
    send(kwcc_pkg::OP_LOAD_TWO, 48'h3, 24'h3);
    send(kwcc_pkg::OP_COMPUTE, '0, '0);

    // Zero lag step and the largest lag counts.
    set_lags(32'd0, 5'd31);
    run_set(3, 3, 0);
    set_lags(32'hFFFF_FFFF, 5'd31);
    run_set(2, 3, 0);

    // Random phases with varied lag settings and idle patterns.
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 3))
        0: step = $urandom_range(1, 1 << 16);
        1: step = $urandom_range(1 << 16, 1 << 19);
        2: step = $urandom();
        default: step = $urandom_range(1, 16);
      endcase
      count = (ph % 4 == 3) ? 5'(CAP_LAGS) : 5'($urandom_range(0, 6));
      set_lags(step, count);
      quiet_phase = (ph % 3 == 0);
      for (int s = 0; s < 6; s++) begin
        noise = $urandom_range(0, 9);
        if (noise == 0) run_set($urandom_range(0, 1), $urandom_range(0, 3), 0);
        else if (noise == 1) run_set($urandom_range(2, 4), $urandom_range(2, 4), 1);
        else if (count > 10) run_set($urandom_range(2, 3), $urandom_range(2, 3), 0);
        else run_set($urandom_range(2, 5), $urandom_range(2, 5), 0);
      end
    end

    wait_idle();
    $display("Checked %0d lag beats from %0d compute requests over %0d cycles.",
             sb.beats_checked, sb.computes_seen, cycles);
    $display("Covered ordered and scrambled series, short sets, edge times and lag settings.");
    if (sb.failures == 0 && sb.lag_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

### files.f
design/kwcc_pkg.sv
design/kwcc_div.sv
design/kwcc_dp.sv
design/kwcc_ctrl.sv
design/kernel_weighted_cross_correlation_unit.sv
bench/kernel_weighted_cross_correlation_unit_test.sv
